[rtl/tpr_pkg.sv]
// Shared types, codes and the Hamming 8/4 decoder for the teletext packet router.
package tpr_pkg;

  localparam int MAGAZINES = 8;
  localparam int MAG_W     = 3;
  localparam int QDEPTH    = 2;

  localparam logic [15:0] SUB_MASK   = 16'h3f7f;
  localparam logic [7:0]  PAGE_XFF   = 8'hff;
  localparam logic [10:0] SERVICE_PG = 11'h0ff;
  localparam logic [4:0]  ROW_HEADER = 5'd0;
  localparam logic [4:0]  ROW_EXT    = 5'd26;
  localparam logic [4:0]  ROW_XFF    = 5'd29;
  localparam logic [4:0]  ROW_SVC    = 5'd30;

  // Result status codes.
  localparam logic [2:0] ST_ROUTED    = 3'd0;
  localparam logic [2:0] ST_CLEARED   = 3'd1;
  localparam logic [2:0] ST_HAM_ERR   = 3'd2;
  localparam logic [2:0] ST_NO_PAGE   = 3'd3;
  localparam logic [2:0] ST_ROW_RANGE = 3'd4;
  localparam logic [2:0] ST_SLOT_RANGE = 3'd5;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_HAM_ERR,
    KIND_NO_PAGE,
    KIND_ROW_RANGE,
    KIND_ROUTE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] page;
    logic [13:0] sub;
    logic [4:0]  row;
    logic [3:0]  dc;
    logic        sd;
  } entry_t;

  typedef struct packed {
    logic       err;
    logic [3:0] nib;
  } ham_t;

  function automatic logic [2:0] ham_pos(input logic [2:0] s);
    logic [2:0] p;
    unique case (s)
      3'd0: p = 3'd6;
      3'd1: p = 3'd0;
      3'd2: p = 3'd2;
      3'd3: p = 3'd7;
      3'd4: p = 3'd4;
      3'd5: p = 3'd5;
      3'd6: p = 3'd3;
      default: p = 3'd1;
    endcase
    return p;
  endfunction

  // Corrects a single bit error; a set overall parity with a nonzero syndrome is fatal.
  function automatic ham_t ham84(input logic [7:0] b);
    logic       pa, pb, pc, d;
    logic [2:0] s;
    logic [7:0] c;
    ham_t       r;
    pa = b[0] ^ b[1] ^ b[5] ^ b[7];
    pb = b[1] ^ b[2] ^ b[3] ^ b[7];
    pc = b[1] ^ b[3] ^ b[4] ^ b[5];
    d  = ^b;
    s  = {~pc, ~pb, ~pa};
    c  = b;
    r.err = 1'b0;
    if (d) begin
      if (s != 3'd0) r.err = 1'b1;
    end else begin
      c[ham_pos(s)] = ~c[ham_pos(s)];
    end
    r.nib = {c[7], c[5], c[3], c[1]};
    return r;
  endfunction

endpackage

[rtl/teletext_packet_router_unit.sv]
// Top level of the teletext packet router: front end, item queue and back end.
//
// Each input item carries the first eight bytes of a teletext line in in_tdata,
// with in_tuser set for a clear item that invalidates every magazine page
// register. Exactly one result item leaves on the out_ channel for each input
// item, in order: status, header and service data flags in out_tuser, and the
// page number, subpage slot and row slot in out_tdata.
// The front end decodes and classifies an item in the cycle it is accepted and
// updates the per-magazine page register at once, so a header is seen by the
// very next item. The back end pops the item from the queue, works out the
// slots and loads the result register, whose valid bit drives out_tvalid.
// Throughput is one item per cycle while out_tready stays high; the only feedback
// loop is the eight-entry magazine register file, read and written in the same cycle.
// A two-entry queue separates the two ends: when the receiver stalls, the
// result register holds, the queue fills, and in_tready falls only once it is
// full. Reset clears every magazine valid bit, empties the queue and drops
// out_tvalid; no clearing pass is needed.
module teletext_packet_router_unit #(
  parameter int ROW_SLOTS     = 512,
  parameter int SUBPAGE_SLOTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // clear
  input  logic [63:0] in_tdata,   // addr_byte0, addr_byte1, units_byte, tens_byte,
                                  // sub_byte0, sub_byte1, sub_byte2, sub_byte3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // page_number, subpage_slot, row_slot
  output logic [4:0]  out_tuser   // status, header_row, service_data
);

  logic            q_full, q_push, q_pop, q_not_empty;
  tpr_pkg::entry_t q_entry, q_head;

  tpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  tpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  tpr_back #(
    .ROW_SLOTS     (ROW_SLOTS),
    .SUBPAGE_SLOTS (SUBPAGE_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

[rtl/tpr_front.sv]
// Front end: accepts items, decodes the address bytes and keeps the magazine page registers.
module tpr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,   // clear
  input  logic [63:0]         in_tdata,   // addr_byte0, addr_byte1, units_byte, tens_byte,
                                          // sub_byte0, sub_byte1, sub_byte2, sub_byte3
  input  logic                q_full,
  output logic                q_push,
  output tpr_pkg::entry_t     q_entry
);

  logic [tpr_pkg::MAGAZINES-1:0] valid_r, valid_nxt;
  logic [7:0]  pn_r  [tpr_pkg::MAGAZINES];
  logic [13:0] sub_r [tpr_pkg::MAGAZINES];

  tpr_pkg::ham_t lo, hi, hu, ht, hs0, hs1, hs2, hs3, hdc;
  logic [tpr_pkg::MAG_W-1:0] mag;
  logic [4:0]  row;
  logic        addr_err, hdr_err, hdr_ok, cur_valid;
  logic [7:0]  new_pn, cur_pn;
  logic [15:0] raw_sub;
  logic [13:0] new_sub, cur_sub;
  logic [3:0]  dc;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    lo  = tpr_pkg::ham84(in_tdata[7:0]);
    hi  = tpr_pkg::ham84(in_tdata[15:8]);
    hu  = tpr_pkg::ham84(in_tdata[23:16]);
    ht  = tpr_pkg::ham84(in_tdata[31:24]);
    hs0 = tpr_pkg::ham84(in_tdata[39:32]);
    hs1 = tpr_pkg::ham84(in_tdata[47:40]);
    hs2 = tpr_pkg::ham84(in_tdata[55:48]);
    hs3 = tpr_pkg::ham84(in_tdata[63:56]);
    hdc = hu;

    mag      = lo.nib[2:0];
    row      = {hi.nib, lo.nib[3]};
    addr_err = lo.err || hi.err;
    hdr_err  = hu.err || ht.err || hs0.err || hs1.err || hs2.err || hs3.err;
    hdr_ok   = !addr_err && (row == tpr_pkg::ROW_HEADER) && !hdr_err;

    new_pn  = {ht.nib, hu.nib};
    raw_sub = {hs3.nib, hs2.nib, hs1.nib, hs0.nib} & tpr_pkg::SUB_MASK;
    new_sub = (new_pn == tpr_pkg::PAGE_XFF) ? 14'd0 : raw_sub[13:0];

    // A header updates its magazine register in the same cycle, so forward it.
    cur_valid = hdr_ok ? 1'b1 : valid_r[mag];
    cur_pn    = hdr_ok ? new_pn : pn_r[mag];
    cur_sub   = hdr_ok ? new_sub : sub_r[mag];

    // Designation code: zero for rows below 26, and a bad byte counts as zero.
    dc = (row >= tpr_pkg::ROW_EXT && !hdc.err) ? hdc.nib : 4'd0;

    q_entry.kind = tpr_pkg::KIND_ROUTE;
    q_entry.page = {mag, cur_pn};
    q_entry.sub  = (cur_pn == tpr_pkg::PAGE_XFF) ? 14'd0 : cur_sub;
    q_entry.row  = row;
    q_entry.dc   = dc;
    q_entry.sd   = 1'b0;

    if (in_tuser) begin
      q_entry.kind = tpr_pkg::KIND_CLEAR;
    end else if (addr_err || (row == tpr_pkg::ROW_HEADER && hdr_err)) begin
      q_entry.kind = tpr_pkg::KIND_HAM_ERR;
    end else if (row == tpr_pkg::ROW_SVC && mag == '0) begin
      q_entry.page = tpr_pkg::SERVICE_PG;
      q_entry.sub  = 14'd0;
      q_entry.sd   = 1'b1;
    end else if (!cur_valid) begin
      q_entry.kind = tpr_pkg::KIND_NO_PAGE;
    end else if (row == tpr_pkg::ROW_XFF) begin
      q_entry.page = {mag, tpr_pkg::PAGE_XFF};
      q_entry.sub  = 14'd0;
    end else if (row > tpr_pkg::ROW_XFF) begin
      q_entry.kind = tpr_pkg::KIND_ROW_RANGE;
    end

    valid_nxt = valid_r;
    if (q_push) begin
      if (in_tuser) valid_nxt = '0;
      else if (hdr_ok) valid_nxt[mag] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push && !in_tuser && hdr_ok) begin
      pn_r[mag]  <= new_pn;
      sub_r[mag] <= new_sub;
    end
  end

endmodule

[rtl/tpr_queue.sv]
// Short queue of classified items between the front and back ends.
module tpr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tpr_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output tpr_pkg::entry_t head
);

  localparam int PW = $clog2(tpr_pkg::QDEPTH);
  localparam int CW = $clog2(tpr_pkg::QDEPTH + 1);

  tpr_pkg::entry_t slot_r [tpr_pkg::QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(tpr_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(tpr_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(tpr_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_entry;
  end

endmodule

[rtl/tpr_back.sv]
// Back end: works out the subpage and row slots and holds the result register.
module tpr_back #(
  parameter int ROW_SLOTS     = 512,
  parameter int SUBPAGE_SLOTS = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  tpr_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // page_number, subpage_slot, row_slot
  output logic [4:0]      out_tuser   // status, header_row, service_data
);

  logic        valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [10:0] page_r, page_nxt;
  logic [11:0] spn_r, spn_nxt;
  logic [8:0]  rs_r, rs_nxt;
  logic        hd_r, hd_nxt, sd_r, sd_nxt;

  logic [12:0] spn;
  logic [9:0]  ext;

  assign q_pop      = q_not_empty && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = {rs_r, spn_r, page_r};
  assign out_tuser  = {sd_r, hd_r, status_r};

  always_comb begin
    spn = 13'(q_head.sub[3:0])
        + 13'(q_head.sub[6:4]) * 13'd10
        + 13'(q_head.sub[11:8]) * 13'd80
        + 13'(q_head.sub[13:12]) * 13'd1000;
    ext = {1'b0, q_head.row, 4'd0} + 10'(q_head.dc);

    status_nxt = tpr_pkg::ST_ROUTED;
    page_nxt   = '0;
    spn_nxt    = '0;
    rs_nxt     = '0;
    hd_nxt     = 1'b0;
    sd_nxt     = 1'b0;
    unique case (q_head.kind)
      tpr_pkg::KIND_CLEAR:     status_nxt = tpr_pkg::ST_CLEARED;
      tpr_pkg::KIND_HAM_ERR:   status_nxt = tpr_pkg::ST_HAM_ERR;
      tpr_pkg::KIND_NO_PAGE:   status_nxt = tpr_pkg::ST_NO_PAGE;
      tpr_pkg::KIND_ROW_RANGE: status_nxt = tpr_pkg::ST_ROW_RANGE;
      tpr_pkg::KIND_ROUTE: begin
        if (ext >= 10'(ROW_SLOTS)) begin
          status_nxt = tpr_pkg::ST_ROW_RANGE;
        end else begin
          // An out-of-range subpage still stores the packet, at slot zero.
          if (spn >= 13'(SUBPAGE_SLOTS)) begin
            status_nxt = tpr_pkg::ST_SLOT_RANGE;
          end else begin
            spn_nxt = spn[11:0];
          end
          page_nxt = q_head.page;
          rs_nxt   = ext[8:0];
          hd_nxt   = (q_head.row == tpr_pkg::ROW_HEADER);
          sd_nxt   = q_head.sd;
        end
      end
      default: status_nxt = tpr_pkg::ST_HAM_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      page_r   <= page_nxt;
      spn_r    <= spn_nxt;
      rs_r     <= rs_nxt;
      hd_r     <= hd_nxt;
      sd_r     <= sd_nxt;
    end
  end

endmodule
